>>> sv/ca3d_pkg.sv
// Package for the 3D multi-species life cell update: widths, constants,
// pipeline stage structs and register indices. No dependencies.
`default_nettype none
package ca3d_pkg;

   localparam int SPECIES      = 9;
   localparam int CELL_W       = 4;
   localparam int PLANE_CELLS  = 9;
   localparam int PLANE_W      = PLANE_CELLS * CELL_W;
   localparam int CELLS        = 3 * PLANE_CELLS;
   localparam int NEIGHBOURS   = CELLS - 1;
   localparam int CENTRE_CELL  = PLANE_CELLS + 4;
   localparam int COUNT_W      = 5;

   typedef logic [PLANE_W-1:0]    plane_type;
   typedef logic [CELL_W-1:0]     cell_type;
   typedef logic [COUNT_W-1:0]    count_type;
   typedef logic [NEIGHBOURS-1:0] nvec_type;
   typedef logic [1:0]            csr_index_type;

   localparam csr_index_type CSR_SURVIVE_MIN = 2'd0;
   localparam csr_index_type CSR_SURVIVE_MAX = 2'd1;
   localparam csr_index_type CSR_BIRTH_MIN   = 2'd2;
   localparam csr_index_type CSR_BIRTH_MAX   = 2'd3;

   localparam count_type SURVIVE_MIN_RESET = 5'd5;
   localparam count_type SURVIVE_MAX_RESET = 5'd13;
   localparam count_type BIRTH_MIN_RESET   = 5'd7;
   localparam count_type BIRTH_MAX_RESET   = 5'd10;

   typedef struct packed {
      count_type survive_min;
      count_type survive_max;
      count_type birth_min;
      count_type birth_max;
   } cfg_type;

   typedef struct packed {
      logic                       bad;
      cell_type                   centre;
      nvec_type                   live;
      logic [SPECIES:1][NEIGHBOURS-1:0] match;
   } dec_type;

   typedef struct packed {
      logic                     bad;
      cell_type                 centre;
      count_type                live_cnt;
      logic [SPECIES:1][COUNT_W-1:0] tally;
   } tally_type;

endpackage
`default_nettype wire

>>> sv/ca3d_req_if.sv
// Request channel: valid/ready handshake carrying the three cell planes.
// Depends on ca3d_pkg.
`default_nettype none
interface ca3d_req_if;
   logic                valid;
   logic                ready;
   ca3d_pkg::plane_type plane_before;
   ca3d_pkg::plane_type plane_middle;
   ca3d_pkg::plane_type plane_after;

   modport source (output valid, plane_before, plane_middle, plane_after, input ready);
   modport sink   (input valid, plane_before, plane_middle, plane_after, output ready);
endinterface
`default_nettype wire

>>> sv/ca3d_rsp_if.sv
// Response channel: valid/ready handshake carrying the next cell value.
// Depends on ca3d_pkg.
`default_nettype none
interface ca3d_rsp_if;
   logic               valid;
   logic               ready;
   ca3d_pkg::cell_type next_cell;
   logic               bad_input;

   modport source (output valid, next_cell, bad_input, input ready);
   modport sink   (input valid, next_cell, bad_input, output ready);
endinterface
`default_nettype wire

>>> sv/ca3d_decode.sv
// Stage 1: decode the 27 cells into live and per-species match vectors.
// Depends on ca3d_pkg.
`default_nettype none
module ca3d_decode (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                in_valid,
   output logic                     in_ready,
   input  wire ca3d_pkg::plane_type plane_before,
   input  wire ca3d_pkg::plane_type plane_middle,
   input  wire ca3d_pkg::plane_type plane_after,
   output logic                     out_valid,
   input  wire logic                out_ready,
   output ca3d_pkg::dec_type        out_data
);
   import ca3d_pkg::*;

   logic [CELLS*CELL_W-1:0] cells;
   dec_type                 dec_in;
   dec_type                 dec_ff;
   logic                    valid_ff;

   assign cells = {plane_after, plane_middle, plane_before};

   always_comb begin
      cell_type c;
      int       k;
      dec_in = '0;
      for (int i = 0; i < CELLS; i++) begin
         if (cells[i*CELL_W +: CELL_W] > cell_type'(SPECIES)) begin
            dec_in.bad = 1'b1;
         end
      end
      dec_in.centre = cells[CENTRE_CELL*CELL_W +: CELL_W];
      for (int n = 0; n < NEIGHBOURS; n++) begin
         k = (n < CENTRE_CELL) ? n : n + 1;
         c = cells[k*CELL_W +: CELL_W];
         dec_in.live[n] = (c != '0);
         for (int s = 1; s <= SPECIES; s++) begin
            dec_in.match[s][n] = (c == cell_type'(s));
         end
      end
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         dec_ff <= dec_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = dec_ff;
endmodule
`default_nettype wire

>>> sv/ca3d_tally.sv
// Stage 2: count live neighbours and tally each species.
// Depends on ca3d_pkg.
`default_nettype none
module ca3d_tally (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire ca3d_pkg::dec_type in_data,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output ca3d_pkg::tally_type    out_data
);
   import ca3d_pkg::*;

   tally_type tally_in;
   tally_type tally_ff;
   logic      valid_ff;

   always_comb begin
      tally_in.bad      = in_data.bad;
      tally_in.centre   = in_data.centre;
      tally_in.live_cnt = count_type'($countones(in_data.live));
      for (int s = 1; s <= SPECIES; s++) begin
         tally_in.tally[s] = count_type'($countones(in_data.match[s]));
      end
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         tally_ff <= tally_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = tally_ff;
endmodule
`default_nettype wire

>>> sv/ca3d_select.sv
// Stage 3: range checks, majority species and the output register.
// Depends on ca3d_pkg.
`default_nettype none
module ca3d_select (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire ca3d_pkg::cfg_type   cfg,
   input  wire logic                in_valid,
   output logic                     in_ready,
   input  wire ca3d_pkg::tally_type in_data,
   output logic                     out_valid,
   input  wire logic                out_ready,
   output ca3d_pkg::cell_type       next_cell,
   output logic                     bad_input
);
   import ca3d_pkg::*;

   cell_type next_in;
   cell_type next_ff;
   logic     bad_ff;
   logic     valid_ff;

   always_comb begin
      cell_type  best;
      count_type best_cnt;
      logic      survive;
      logic      birth;
      best     = cell_type'(1);
      best_cnt = in_data.tally[1];
      for (int s = 2; s <= SPECIES; s++) begin
         if (in_data.tally[s] > best_cnt) begin
            best     = cell_type'(s);
            best_cnt = in_data.tally[s];
         end
      end
      survive = (in_data.live_cnt >= cfg.survive_min) && (in_data.live_cnt <= cfg.survive_max);
      birth   = (in_data.live_cnt >= cfg.birth_min) && (in_data.live_cnt <= cfg.birth_max);
      next_in = '0;
      if (!in_data.bad) begin
         if (in_data.centre != '0) begin
            if (survive) begin
               next_in = in_data.centre;
            end
         end else if (birth) begin
            next_in = best;
         end
      end
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         next_ff <= next_in;
         bad_ff  <= in_data.bad;
      end
   end

   assign out_valid = valid_ff;
   assign next_cell = next_ff;
   assign bad_input = bad_ff;

   a_bad_gives_dead: assert property (@(posedge clock) disable iff (reset)
      valid_ff && bad_ff |-> next_ff == '0)
      else $error("bad transaction produced a live cell");

   a_species_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> next_ff <= cell_type'(SPECIES))
      else $error("next cell outside species range");

   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !out_ready |-> !in_ready)
      else $error("stage accepts while output stalled");

   a_load_on_accept: assert property (@(posedge clock) disable iff (reset)
      in_valid && in_ready |=> valid_ff && bad_ff == $past(in_data.bad))
      else $error("output register missed a transaction");
endmodule
`default_nettype wire

>>> sv/cell_automaton_3d_species_update.sv
// Top level of the 3D multi-species life cell update: configuration
// registers and three pipeline stages. Depends on ca3d_pkg, ca3d_req_if,
// ca3d_rsp_if, ca3d_decode, ca3d_tally and ca3d_select.
//
//   channel   direction  payload
//   req_chan  in         plane_before, plane_middle, plane_after (36 b each)
//   rsp_chan  out        next_cell (4 b), bad_input (1 b)
//   csr_*     in         csr_wr_en, csr_index (2 b), csr_data (5 b)
//
// Three register stages (decode, tally, select); one transaction per cycle
// sustained while rsp_chan.ready stays high.
// Each stage holds its data while the next is full and stalled, so a
// stalled response backs pressure up to req_chan.ready without loss.
// Synchronous reset clears the stage valid bits and loads the default
// survive and birth ranges.
`default_nettype none
module cell_automaton_3d_species_update (
   input  wire logic                    clock,
   input  wire logic                    reset,
   ca3d_req_if.sink                     req_chan,
   ca3d_rsp_if.source                   rsp_chan,
   input  wire logic                    csr_wr_en,
   input  wire ca3d_pkg::csr_index_type csr_index,
   input  wire ca3d_pkg::count_type     csr_data
);
   import ca3d_pkg::*;

   cfg_type   cfg_ff;
   dec_type   dec_data;
   tally_type tally_data;
   logic      dec_valid;
   logic      dec_ready;
   logic      tally_valid;
   logic      tally_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.survive_min <= SURVIVE_MIN_RESET;
         cfg_ff.survive_max <= SURVIVE_MAX_RESET;
         cfg_ff.birth_min   <= BIRTH_MIN_RESET;
         cfg_ff.birth_max   <= BIRTH_MAX_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_SURVIVE_MIN: cfg_ff.survive_min <= csr_data;
            CSR_SURVIVE_MAX: cfg_ff.survive_max <= csr_data;
            CSR_BIRTH_MIN:   cfg_ff.birth_min   <= csr_data;
            CSR_BIRTH_MAX:   cfg_ff.birth_max   <= csr_data;
            default:         cfg_ff             <= cfg_ff;
         endcase
      end
   end

   ca3d_decode u_decode (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_chan.valid),
      .in_ready     (req_chan.ready),
      .plane_before (req_chan.plane_before),
      .plane_middle (req_chan.plane_middle),
      .plane_after  (req_chan.plane_after),
      .out_valid    (dec_valid),
      .out_ready    (dec_ready),
      .out_data     (dec_data)
   );

   ca3d_tally u_tally (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dec_valid),
      .in_ready  (dec_ready),
      .in_data   (dec_data),
      .out_valid (tally_valid),
      .out_ready (tally_ready),
      .out_data  (tally_data)
   );

   ca3d_select u_select (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (tally_valid),
      .in_ready  (tally_ready),
      .in_data   (tally_data),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .next_cell (rsp_chan.next_cell),
      .bad_input (rsp_chan.bad_input)
   );
endmodule
`default_nettype wire

>>> tb/cell_automaton_3d_species_update_test.sv
// Testbench for the 3D multi-species life cell update: random and directed
// neighbourhoods against a predictor of the next centre value.
// Depends on ca3d_pkg, ca3d_req_if, ca3d_rsp_if and cell_automaton_3d_species_update.
`timescale 1ns / 1ps

package ca3d_cell_check_pkg;
   import ca3d_pkg::*;

   typedef struct packed {
      cell_type next_cell;
      logic     bad_input;
   } cell_verdict_type;

   class cell_update_board;
      count_type        survive_lo;
      count_type        survive_hi;
      count_type        birth_lo;
      count_type        birth_hi;
      cell_verdict_type awaited_cells[$];
      int unsigned      failures;

      function new();
         survive_lo = SURVIVE_MIN_RESET;
         survive_hi = SURVIVE_MAX_RESET;
         birth_lo   = BIRTH_MIN_RESET;
         birth_hi   = BIRTH_MAX_RESET;
         failures   = 0;
      endfunction

      function void set_register(csr_index_type idx, count_type value);
         case (idx)
            CSR_SURVIVE_MIN: survive_lo = value;
            CSR_SURVIVE_MAX: survive_hi = value;
            CSR_BIRTH_MIN:   birth_lo   = value;
            CSR_BIRTH_MAX:   birth_hi   = value;
            default: ;
         endcase
      endfunction

      function cell_verdict_type next_generation(plane_type prior, plane_type middle,
                                                 plane_type after);
         plane_type        planes [3];
         int unsigned      tally [16];
         int unsigned      live;
         int unsigned      best;
         cell_type         code;
         cell_type         centre;
         cell_verdict_type verdict;
         planes[0] = prior;
         planes[1] = middle;
         planes[2] = after;
         live      = 0;
         verdict   = '0;
         foreach (tally[s]) tally[s] = 0;
         centre = middle[4*CELL_W +: CELL_W];
         for (int p = 0; p < 3; p++) begin
            for (int i = 0; i < PLANE_CELLS; i++) begin
               code = planes[p][i*CELL_W +: CELL_W];
               if (code > SPECIES) verdict.bad_input = 1'b1;
               if (p == 1 && i == 4) continue;
               if (code != 0) begin
                  live++;
                  tally[code]++;
               end
            end
         end
         if (!verdict.bad_input) begin
            if (centre != 0) begin
               if (live >= survive_lo && live <= survive_hi) verdict.next_cell = centre;
            end else if (live >= birth_lo && live <= birth_hi) begin
               best = 1;
               for (int s = 2; s <= SPECIES; s++) begin
                  if (tally[s] > tally[best]) best = s;
               end
               verdict.next_cell = cell_type'(best);
            end
         end
         return verdict;
      endfunction

      function void note_request(plane_type prior, plane_type middle, plane_type after);
         awaited_cells.push_back(next_generation(prior, middle, after));
      endfunction

      function void check_response(cell_type next_cell, logic bad_input);
         cell_verdict_type want;
         if (awaited_cells.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("unexpected transaction: next_cell %0d bad_input %0b",
                        next_cell, bad_input);
            return;
         end
         want = awaited_cells.pop_front();
         if (want.next_cell !== next_cell || want.bad_input !== bad_input) begin
            failures++;
            if (failures <= 10)
               $display("mismatch: next_cell exp %0d got %0d, bad_input exp %0b got %0b",
                        want.next_cell, next_cell, want.bad_input, bad_input);
         end
      endfunction

      function int unsigned pending();
         return awaited_cells.size();
      endfunction
   endclass
endpackage

module cell_automaton_3d_species_update_test;
   import ca3d_pkg::*;
   import ca3d_cell_check_pkg::*;

   localparam int unsigned LATENCY     = 3;
   localparam int unsigned CYCLE_LIMIT = 400000;

   logic          clock;
   logic          reset;
   logic          csr_wr_en;
   csr_index_type csr_index;
   count_type     csr_data;

   ca3d_req_if req_chan ();
   ca3d_rsp_if rsp_chan ();

   cell_update_board board;
   int unsigned      sent;
   int unsigned      got;
   int unsigned      cycles;

   cell_automaton_3d_species_update i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int unsigned draw_gap(bit calm);
      if (calm) return 0;
      return $urandom_range(0, 14);
   endfunction

   function automatic void pack_planes(input cell_type cells [27], output plane_type prior,
                                       output plane_type middle, output plane_type after);
      plane_type planes [3];
      for (int k = 0; k < CELLS; k++) planes[k/PLANE_CELLS][(k%PLANE_CELLS)*CELL_W +: CELL_W] =
         cells[k];
      prior  = planes[0];
      middle = planes[1];
      after  = planes[2];
   endfunction

   task automatic send_planes(input plane_type prior, input plane_type middle,
                              input plane_type after);
      int unsigned gap;
      gap = draw_gap((sent >= 260 && sent < 460) || (sent / 100) % 5 == 4);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.plane_before <= prior;
      req_chan.plane_middle <= middle;
      req_chan.plane_after  <= after;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      board.note_request(prior, middle, after);
      sent++;
   endtask

   // Place n_a neighbours of species_a, then n_b of species_b, around the centre.
   task automatic send_pattern(input cell_type centre, input int unsigned n_a,
                               input cell_type species_a, input int unsigned n_b,
                               input cell_type species_b);
      cell_type    cells [27];
      plane_type   prior, middle, after;
      int unsigned placed;
      placed = 0;
      for (int k = 0; k < CELLS; k++) begin
         cells[k] = '0;
         if (k == CENTRE_CELL) continue;
         if (placed < n_a) cells[k] = species_a;
         else if (placed < n_a + n_b) cells[k] = species_b;
         placed++;
      end
      cells[CENTRE_CELL] = centre;
      pack_planes(cells, prior, middle, after);
      send_planes(prior, middle, after);
   endtask

   task automatic send_random();
      cell_type    cells [27];
      cell_type    palette [3];
      plane_type   prior, middle, after;
      int unsigned density;
      density = $urandom_range(0, 16);
      foreach (palette[k]) palette[k] = cell_type'($urandom_range(1, SPECIES));
      for (int k = 0; k < CELLS; k++) begin
         if ($urandom_range(0, 15) >= density) cells[k] = '0;
         else if ($urandom_range(0, 3) == 0) cells[k] = cell_type'($urandom_range(1, SPECIES));
         else cells[k] = palette[$urandom_range(0, 2)];
      end
      cells[CENTRE_CELL] = $urandom_range(0, 1) ? palette[0] : cell_type'(0);
      if ($urandom_range(0, 11) == 0)
         cells[$urandom_range(0, CELLS - 1)] = cell_type'($urandom_range(SPECIES + 1, 15));
      pack_planes(cells, prior, middle, after);
      if ($urandom_range(0, 39) == 0) begin
         prior  = plane_type'({$urandom, $urandom});
         middle = plane_type'({$urandom, $urandom});
         after  = plane_type'({$urandom, $urandom});
      end
      send_planes(prior, middle, after);
   endtask

   task automatic drain_pipeline();
      req_chan.valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (LATENCY + 3) @(posedge clock);
   endtask

   task automatic write_ranges(input count_type s_lo, input count_type s_hi,
                               input count_type b_lo, input count_type b_hi);
      csr_index_type idx [4];
      count_type     value [4];
      idx   = '{CSR_SURVIVE_MIN, CSR_SURVIVE_MAX, CSR_BIRTH_MIN, CSR_BIRTH_MAX};
      value = '{s_lo, s_hi, b_lo, b_hi};
      drain_pipeline();
      for (int r = 0; r < 4; r++) begin
         csr_wr_en <= 1'b1;
         csr_index <= idx[r];
         csr_data  <= value[r];
         board.set_register(idx[r], value[r]);
         @(posedge clock);
      end
      csr_wr_en <= 1'b0;
   endtask

   task automatic run_random(input int unsigned count);
      send_planes('0, '0, '0);
      send_planes(36'h999999999, 36'h999999999, 36'h999999999);
      repeat (count) send_random();
   endtask

   initial begin : watchdog
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("Some tests failed");
      $finish;
   end

   initial begin : response_sink
      int unsigned rsp_wait;
      int unsigned hold_left;
      rsp_chan.ready <= 1'b0;
      rsp_wait  = 0;
      hold_left = 0;
      got       = 0;
      wait (reset === 1'b0);
      forever begin
         @(posedge clock);
         if (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
            board.check_response(rsp_chan.next_cell, rsp_chan.bad_input);
            got++;
            rsp_wait = draw_gap((got / 120) % 4 == 3);
            // hold off long enough for the pipeline to fill and stall the request side
            if (got == 300) hold_left = 80;
         end else if (rsp_wait > 0 && rsp_chan.ready !== 1'b1) begin
            rsp_wait--;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= (rsp_wait == 0);
         end
      end
   end

   initial begin : stimulus
      board = new();
      sent  = 0;
      clock = 1'b0;
      reset = 1'b1;
      csr_wr_en             <= 1'b0;
      csr_index             <= CSR_SURVIVE_MIN;
      csr_data              <= '0;
      req_chan.valid        <= 1'b0;
      req_chan.plane_before <= '0;
      req_chan.plane_middle <= '0;
      req_chan.plane_after  <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_planes('0, '0, '0);
      send_planes(36'h999999999, 36'h999999999, 36'h999999999);
      send_planes(36'hFFFFFFFFF, 36'hFFFFFFFFF, 36'hFFFFFFFFF);
      send_planes(36'h00000000A, '0, '0);
      send_planes('0, '0, 36'hF00000000);
      send_planes('0, 36'h0000A0000, '0);
      send_pattern(4'd15, 6, 4'd2, 0, 4'd0);
      send_pattern(4'd3, 5, 4'd3, 0, 4'd0);
      send_pattern(4'd3, 4, 4'd3, 0, 4'd0);
      send_pattern(4'd3, 13, 4'd1, 0, 4'd0);
      send_pattern(4'd3, 14, 4'd1, 0, 4'd0);
      send_pattern(4'd9, 6, 4'd9, 6, 4'd4);
      send_pattern(4'd0, 4, 4'd6, 4, 4'd2);
      send_pattern(4'd0, 5, 4'd7, 5, 4'd3);
      send_pattern(4'd0, 11, 4'd5, 0, 4'd0);
      send_pattern(4'd0, 6, 4'd5, 0, 4'd0);
      send_pattern(4'd0, 7, 4'd9, 0, 4'd0);
      send_pattern(4'd0, 3, 4'd1, 4, 4'd8);
      send_pattern(4'd0, 9, 4'd1, 1, 4'd9);
      repeat (250) send_random();

      write_ranges(5'd0, 5'd26, 5'd0, 5'd26);
      run_random(200);
      write_ranges(5'd20, 5'd3, 5'd15, 5'd2);
      run_random(150);
      write_ranges(5'd26, 5'd31, 5'd0, 5'd31);
      run_random(150);
      write_ranges(5'd31, 5'd31, 5'd31, 5'd31);
      run_random(75);
      write_ranges(5'd0, 5'd0, 5'd0, 5'd0);
      run_random(100);
      repeat (2) begin
         write_ranges(count_type'($urandom_range(0, 31)), count_type'($urandom_range(0, 31)),
                      count_type'($urandom_range(0, 31)), count_type'($urandom_range(0, 31)));
         run_random(175);
      end

      drain_pipeline();
      repeat (LATENCY * 4) @(posedge clock);
      if (board.failures == 0 && board.pending() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end
endmodule
